// ===== design/dalm_pkg.sv =====
`timescale 1ns / 1ps

package dalm_pkg;

   localparam int unsigned DOOR_COUNT_DEF = 4;
   localparam int unsigned OPEN_BITS      = 4;
   localparam int unsigned TIME_W         = 32;
   localparam int unsigned SETTLE_W       = 16;
   localparam int unsigned LEVEL_W        = 8;
   localparam int unsigned MODE_W         = 3;
   localparam int unsigned PACKED_DOORS   = 4;

   localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd1000;
   localparam logic [LEVEL_W-1:0]  BOOST_LIMIT  = 8'd100;

   typedef enum logic [MODE_W-1:0] {
      M_IDLE_INIT  = 3'd0,
      M_IDLE       = 3'd1,
      M_OPEN       = 3'd2,
      M_DOOR_WAIT  = 3'd3,
      M_WAIT       = 3'd4,
      M_BLIND      = 3'd5,
      M_TURN       = 3'd6,
      M_TURN_BLIND = 3'd7
   } mode_type;

   typedef struct packed {
      logic any_open;
      logic display_on;
      logic side_en;
      logic side_warn;
      logic turning;
   } step_ctl_type;

   typedef struct packed {
      logic [TIME_W-1:0]    now_ms;
      logic [OPEN_BITS-1:0] open_mask;
      logic                 display_on;
      logic                 blind_spot_right;
      logic                 blind_spot_left;
      logic                 turn_right;
      logic                 turn_left;
      logic                 indicator_right;
      logic                 indicator_left;
      logic [LEVEL_W-1:0]   level_in;
      logic                 clear_changed;
   } in_beat_type;

endpackage

// ===== design/dalm_door.sv =====
`timescale 1ns / 1ps

module dalm_door (
   input  dalm_pkg::mode_type                    mode_in,
   input  logic [dalm_pkg::TIME_W-1:0]           stamp_in,
   input  logic [dalm_pkg::TIME_W-1:0]           now_ms,
   input  logic [dalm_pkg::SETTLE_W-1:0]         settle_ms,
   input  logic                                  door_is_open,
   input  dalm_pkg::step_ctl_type                ctl,
   output dalm_pkg::mode_type                    mode_out,
   output logic [dalm_pkg::TIME_W-1:0]           stamp_out,
   output logic [dalm_pkg::TIME_W-1:0]           age_out,
   output logic                                  touched
);
   import dalm_pkg::*;

   logic [TIME_W-1:0] elapsed;
   mode_type          m;
   logic              full;
   logic              sub;

   assign elapsed = now_ms - stamp_in;

   always_comb begin
      m    = mode_in;
      full = 1'b0;
      sub  = 1'b0;

      if (m == M_IDLE_INIT && elapsed > {{(TIME_W-SETTLE_W){1'b0}}, settle_ms}) begin
         m    = M_IDLE;
         full = 1'b1;
      end

      if (door_is_open && m != M_OPEN) begin
         m    = M_OPEN;
         full = 1'b1;
      end
      if (!door_is_open && m == M_OPEN) begin
         m    = M_IDLE_INIT;
         full = 1'b1;
      end

      if (ctl.any_open) begin
         if (!door_is_open && m != M_DOOR_WAIT) begin
            m    = M_DOOR_WAIT;
            full = 1'b1;
         end
      end else if (m == M_DOOR_WAIT) begin
         m    = M_IDLE_INIT;
         full = 1'b1;
      end

      if (!ctl.display_on) begin
         if (m inside {M_IDLE, M_IDLE_INIT}) begin
            m    = M_WAIT;
            full = 1'b1;
         end
      end else if (m == M_WAIT) begin
         m    = M_IDLE_INIT;
         full = 1'b1;
      end

      if (ctl.side_en) begin
         if (ctl.side_warn) begin
            if (m == M_IDLE) begin
               m    = M_BLIND;
               full = 1'b1;
            end
            if (m == M_TURN) begin
               m   = M_TURN_BLIND;
               sub = 1'b1;
            end
         end else begin
            if (m == M_BLIND) begin
               m    = M_IDLE;
               full = 1'b1;
            end
            if (m == M_TURN_BLIND) begin
               m   = M_TURN;
               sub = 1'b1;
            end
         end
         if (ctl.turning && m == M_IDLE) begin
            m    = M_TURN;
            full = 1'b1;
         end
         if (ctl.turning && m == M_BLIND) begin
            m   = M_TURN_BLIND;
            sub = 1'b1;
         end
         if (!ctl.turning && m == M_TURN) begin
            m    = M_IDLE;
            full = 1'b1;
         end
         if (!ctl.turning && m == M_TURN_BLIND) begin
            m    = M_BLIND;
            full = 1'b1;
         end
      end
   end

   assign mode_out  = m;
   assign touched   = full | sub;
   assign stamp_out = full ? now_ms : stamp_in;
   assign age_out   = full ? '0 : elapsed;

endmodule

// ===== design/door_ambient_light_mode_fsm.sv =====
`timescale 1ns / 1ps
// An accepted request beat sits in the input register, then moves to the result register.
// Throughput: one beat per cycle while rsp_stall is low; all door rules settle
//   between the input and result registers; door state updates as a beat moves on.
// Reset (synchronous, active high): doors go to idle-init with zero stamps,
//   stored level and change flag clear, settle time returns to 1000 ms.

module door_ambient_light_mode_fsm #(
   parameter int unsigned DOOR_COUNT = dalm_pkg::DOOR_COUNT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  csr_write_enable,
   input  logic [dalm_pkg::SETTLE_W-1:0]         csr_write_data,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [dalm_pkg::TIME_W-1:0]           req_now_ms,
   input  logic [dalm_pkg::OPEN_BITS-1:0]        req_door_open,
   input  logic                                  req_display_on,
   input  logic                                  req_blind_spot_right,
   input  logic                                  req_blind_spot_left,
   input  logic                                  req_turn_right,
   input  logic                                  req_turn_left,
   input  logic                                  req_indicator_right,
   input  logic                                  req_indicator_left,
   input  logic [dalm_pkg::LEVEL_W-1:0]          req_level_in,
   input  logic                                  req_clear_changed,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [dalm_pkg::MODE_W*dalm_pkg::PACKED_DOORS-1:0] rsp_door_modes,
   output logic [dalm_pkg::LEVEL_W-1:0]          rsp_level_out,
   output logic                                  rsp_any_door_open,
   output logic                                  rsp_all_waiting,
   output logic                                  rsp_all_idle,
   output logic                                  rsp_changed,
   output logic [dalm_pkg::TIME_W-1:0]           rsp_age_door0,
   output logic [dalm_pkg::TIME_W-1:0]           rsp_age_door1,
   output logic [dalm_pkg::TIME_W-1:0]           rsp_age_door2,
   output logic [dalm_pkg::TIME_W-1:0]           rsp_age_door3
);
   import dalm_pkg::*;

   localparam int unsigned MODES_W = MODE_W * PACKED_DOORS;

   logic                  in_valid_ff, in_valid_in;
   in_beat_type           in_beat_ff, in_beat_in;
   logic                  req_accept;
   logic                  fire;

   logic [SETTLE_W-1:0]   settle_ff;
   mode_type              door_mode_ff  [DOOR_COUNT];
   logic [TIME_W-1:0]     door_stamp_ff [DOOR_COUNT];
   logic [LEVEL_W-1:0]    light_level_ff, light_level_in;
   logic                  change_flag_ff, change_flag_in;

   mode_type              mode_next  [DOOR_COUNT];
   logic [TIME_W-1:0]     stamp_next [DOOR_COUNT];
   logic [TIME_W-1:0]     door_age   [DOOR_COUNT];
   logic [DOOR_COUNT-1:0] door_touched;
   logic [DOOR_COUNT-1:0] door_op;

   logic                  any_open;
   logic                  all_wait_in, all_idle_in;
   logic [MODES_W-1:0]    modes_in;
   logic [TIME_W-1:0]     age_in [PACKED_DOORS];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MODES_W-1:0]    rsp_modes_ff;
   logic [LEVEL_W-1:0]    rsp_level_ff;
   logic                  rsp_any_open_ff;
   logic                  rsp_all_wait_ff;
   logic                  rsp_all_idle_ff;
   logic                  rsp_changed_ff;
   logic [TIME_W-1:0]     rsp_age_ff [PACKED_DOORS];

   // handshake
   assign fire         = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_accept   = req_valid && !req_stall;
   assign in_valid_in  = req_accept || (in_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_comb begin
      in_beat_in = in_beat_ff;
      if (req_accept) begin
         in_beat_in.now_ms           = req_now_ms;
         in_beat_in.open_mask        = req_door_open;
         in_beat_in.display_on       = req_display_on;
         in_beat_in.blind_spot_right = req_blind_spot_right;
         in_beat_in.blind_spot_left  = req_blind_spot_left;
         in_beat_in.turn_right       = req_turn_right;
         in_beat_in.turn_left        = req_turn_left;
         in_beat_in.indicator_right  = req_indicator_right;
         in_beat_in.indicator_left   = req_indicator_left;
         in_beat_in.level_in         = req_level_in;
         in_beat_in.clear_changed    = req_clear_changed;
      end
   end

   assign any_open = |door_op;

   // per-door rules
   genvar g;
   generate
      for (g = 0; g < DOOR_COUNT; g++) begin : g_door
         step_ctl_type ctl;

         if (g < OPEN_BITS) begin : g_open
            assign door_op[g] = in_beat_ff.open_mask[g];
         end else begin : g_closed
            assign door_op[g] = 1'b0;
         end

         if (g == 0) begin : g_right
            assign ctl.side_en    = 1'b1;
            assign ctl.side_warn  = in_beat_ff.blind_spot_right;
            assign ctl.turning    = in_beat_ff.turn_right | in_beat_ff.indicator_right;
         end else if (g == 1) begin : g_left
            assign ctl.side_en    = 1'b1;
            assign ctl.side_warn  = in_beat_ff.blind_spot_left;
            assign ctl.turning    = in_beat_ff.turn_left | in_beat_ff.indicator_left;
         end else begin : g_rear
            assign ctl.side_en    = 1'b0;
            assign ctl.side_warn  = 1'b0;
            assign ctl.turning    = 1'b0;
         end
         assign ctl.any_open   = any_open;
         assign ctl.display_on = in_beat_ff.display_on;

         dalm_door u_door (
            .mode_in      (door_mode_ff[g]),
            .stamp_in     (door_stamp_ff[g]),
            .now_ms       (in_beat_ff.now_ms),
            .settle_ms    (settle_ff),
            .door_is_open (door_op[g]),
            .ctl          (ctl),
            .mode_out     (mode_next[g]),
            .stamp_out    (stamp_next[g]),
            .age_out      (door_age[g]),
            .touched      (door_touched[g])
         );
      end

      for (g = 0; g < PACKED_DOORS; g++) begin : g_pack
         if (g < DOOR_COUNT) begin : g_used
            assign modes_in[MODE_W*g +: MODE_W] = mode_next[g];
            assign age_in[g]                    = door_age[g];
         end else begin : g_absent
            assign modes_in[MODE_W*g +: MODE_W] = '0;
            assign age_in[g]                    = '0;
         end
      end
   endgenerate

   always_comb begin
      all_wait_in = 1'b1;
      all_idle_in = 1'b1;
      for (int i = 0; i < DOOR_COUNT; i++) begin
         all_wait_in = all_wait_in && (mode_next[i] == M_WAIT);
         all_idle_in = all_idle_in && (mode_next[i] == M_IDLE);
      end
   end

   always_comb begin
      change_flag_in = (change_flag_ff && !in_beat_ff.clear_changed) || (|door_touched) ||
                       (light_level_ff != in_beat_ff.level_in);
      light_level_in = in_beat_ff.level_in;
      if (any_open && in_beat_ff.level_in < BOOST_LIMIT) begin
         light_level_in = in_beat_ff.level_in + BOOST_LIMIT;
      end
   end

   // control and door state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         settle_ff      <= SETTLE_RESET;
         light_level_ff <= '0;
         change_flag_ff <= 1'b0;
         for (int i = 0; i < DOOR_COUNT; i++) begin
            door_mode_ff[i]  <= M_IDLE_INIT;
            door_stamp_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            settle_ff <= csr_write_data;
         end
         if (fire) begin
            light_level_ff <= light_level_in;
            change_flag_ff <= change_flag_in;
            for (int i = 0; i < DOOR_COUNT; i++) begin
               door_mode_ff[i]  <= mode_next[i];
               door_stamp_ff[i] <= stamp_next[i];
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      in_beat_ff <= in_beat_in;
      if (fire) begin
         rsp_modes_ff    <= modes_in;
         rsp_level_ff    <= light_level_in;
         rsp_any_open_ff <= any_open;
         rsp_all_wait_ff <= all_wait_in;
         rsp_all_idle_ff <= all_idle_in;
         rsp_changed_ff  <= change_flag_in;
         for (int i = 0; i < PACKED_DOORS; i++) begin
            rsp_age_ff[i] <= age_in[i];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_door_modes    = rsp_modes_ff;
   assign rsp_level_out     = rsp_level_ff;
   assign rsp_any_door_open = rsp_any_open_ff;
   assign rsp_all_waiting   = rsp_all_wait_ff;
   assign rsp_all_idle      = rsp_all_idle_ff;
   assign rsp_changed       = rsp_changed_ff;
   assign rsp_age_door0     = rsp_age_ff[0];
   assign rsp_age_door1     = rsp_age_ff[1];
   assign rsp_age_door2     = rsp_age_ff[2];
   assign rsp_age_door3     = rsp_age_ff[3];

`ifndef SYNTH
   a_changed_tracks_flag: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_changed == change_flag_ff))
      else $error("result change flag differs from stored flag");

   a_wait_idle_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_all_idle && rsp_all_waiting))
      else $error("all-idle and all-waiting both set");

   a_stall_needs_beat: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("request stalled with free stages");

   a_boost_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_any_door_open) |-> (rsp_level_out >= BOOST_LIMIT))
      else $error("open door without boosted level");
`endif

endmodule

// ===== sim/tb_door_ambient_light_mode_fsm.sv =====
`timescale 1ns / 1ps

module tb_door_ambient_light_mode_fsm;
   import dalm_pkg::*;

   localparam int DOORS       = DOOR_COUNT_DEF;
   localparam int PHASES      = 6;
   localparam int PHASE_BEATS = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 4;
   localparam int SHOWN_MAX   = 10;

   typedef struct packed {
      logic [MODE_W*PACKED_DOORS-1:0]   door_modes;
      logic [LEVEL_W-1:0]               level_out;
      logic                             any_door_open;
      logic                             all_waiting;
      logic                             all_idle;
      logic                             changed;
      logic [PACKED_DOORS-1:0][TIME_W-1:0] ages;
   } light_status_type;

   class light_mode_scoreboard;
      mode_type            door_mode [DOORS];
      logic [TIME_W-1:0]   door_stamp [DOORS];
      logic [LEVEL_W-1:0]  held_level;
      logic                change_flag;
      logic [SETTLE_W-1:0] settle_ms;
      light_status_type    pending [$];
      int                  mismatches;

      function new();
         int i;
         for (i = 0; i < DOORS; i++) begin
            door_mode[i]  = M_IDLE_INIT;
            door_stamp[i] = '0;
         end
         held_level  = '0;
         change_flag = 1'b0;
         settle_ms   = SETTLE_RESET;
         mismatches  = 0;
      endfunction

      function void set_settle(logic [SETTLE_W-1:0] value);
         settle_ms = value;
      endfunction

      function void restamp(int d, mode_type m, logic [TIME_W-1:0] now);
         door_mode[d]  = m;
         door_stamp[d] = now;
         change_flag   = 1'b1;
      endfunction

      function void swap_mode(int d, mode_type m);
         door_mode[d] = m;
         change_flag  = 1'b1;
      endfunction

      function void note_request(in_beat_type b);
         light_status_type   st;
         logic [TIME_W-1:0]  elapsed;
         logic [LEVEL_W-1:0] old_level;
         logic               any_open, all_wait, all_idle, op, bs, tn;
         int                 i;
         st       = '0;
         any_open = 1'b0;
         all_wait = 1'b1;
         all_idle = 1'b1;
         if (b.clear_changed) change_flag = 1'b0;
         for (i = 0; i < DOORS; i++) begin
            elapsed = b.now_ms - door_stamp[i];
            if (door_mode[i] == M_IDLE_INIT && elapsed > TIME_W'(settle_ms))
               restamp(i, M_IDLE, b.now_ms);
         end
         for (i = 0; i < DOORS; i++) begin
            op = (i < OPEN_BITS) ? b.open_mask[i] : 1'b0;
            any_open = any_open | op;
            if (op && door_mode[i] != M_OPEN) restamp(i, M_OPEN, b.now_ms);
            if (!op && door_mode[i] == M_OPEN) restamp(i, M_IDLE_INIT, b.now_ms);
         end
         for (i = 0; i < DOORS; i++) begin
            op = (i < OPEN_BITS) ? b.open_mask[i] : 1'b0;
            if (any_open) begin
               if (!op && door_mode[i] != M_DOOR_WAIT) restamp(i, M_DOOR_WAIT, b.now_ms);
            end else if (door_mode[i] == M_DOOR_WAIT) begin
               restamp(i, M_IDLE_INIT, b.now_ms);
            end
         end
         for (i = 0; i < DOORS; i++) begin
            if (!b.display_on) begin
               if (door_mode[i] inside {M_IDLE, M_IDLE_INIT})
                  restamp(i, M_WAIT, b.now_ms);
            end else if (door_mode[i] == M_WAIT) begin
               restamp(i, M_IDLE_INIT, b.now_ms);
            end
         end
         for (i = 0; i < 2; i++) begin
            bs = (i == 0) ? b.blind_spot_right : b.blind_spot_left;
            tn = (i == 0) ? (b.turn_right | b.indicator_right)
                          : (b.turn_left | b.indicator_left);
            if (bs) begin
               if (door_mode[i] == M_IDLE) restamp(i, M_BLIND, b.now_ms);
               if (door_mode[i] == M_TURN) swap_mode(i, M_TURN_BLIND);
            end else begin
               if (door_mode[i] == M_BLIND) restamp(i, M_IDLE, b.now_ms);
               if (door_mode[i] == M_TURN_BLIND) swap_mode(i, M_TURN);
            end
            if (tn && door_mode[i] == M_IDLE) restamp(i, M_TURN, b.now_ms);
            if (tn && door_mode[i] == M_BLIND) swap_mode(i, M_TURN_BLIND);
            if (!tn && door_mode[i] == M_TURN) restamp(i, M_IDLE, b.now_ms);
            if (!tn && door_mode[i] == M_TURN_BLIND) restamp(i, M_BLIND, b.now_ms);
         end
         for (i = 0; i < DOORS; i++) begin
            all_wait = all_wait & (door_mode[i] == M_WAIT);
            all_idle = all_idle & (door_mode[i] == M_IDLE);
         end
         old_level  = held_level;
         held_level = b.level_in;
         if (old_level != held_level) change_flag = 1'b1;
         if (any_open && held_level < BOOST_LIMIT) held_level = held_level + BOOST_LIMIT;
         for (i = 0; i < DOORS && i < PACKED_DOORS; i++)
            st.door_modes[MODE_W*i +: MODE_W] = door_mode[i];
         st.level_out     = held_level;
         st.any_door_open = any_open;
         st.all_waiting   = all_wait;
         st.all_idle      = all_idle;
         st.changed       = change_flag;
         for (i = 0; i < PACKED_DOORS; i++)
            st.ages[i] = (i < DOORS) ? b.now_ms - door_stamp[i] : '0;
         pending.push_back(st);
      endfunction

      function void field_ok(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= SHOWN_MAX)
               $display("mismatch %s: expected %0h, got %0h", name, want, got);
         end
      endfunction

      function void check_result(light_status_type got);
         light_status_type want;
         int               i;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_MAX)
               $display("mismatch: result beat with nothing pending, modes %0h", got.door_modes);
         end else begin
            want = pending.pop_front();
            field_ok("door_modes", want.door_modes, got.door_modes);
            field_ok("level_out", want.level_out, got.level_out);
            field_ok("any_door_open", want.any_door_open, got.any_door_open);
            field_ok("all_waiting", want.all_waiting, got.all_waiting);
            field_ok("all_idle", want.all_idle, got.all_idle);
            field_ok("changed", want.changed, got.changed);
            for (i = 0; i < PACKED_DOORS; i++)
               field_ok($sformatf("age_door%0d", i), want.ages[i], got.ages[i]);
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             csr_write_enable;
   logic [SETTLE_W-1:0]              csr_write_data;
   logic                             req_valid;
   logic                             req_stall;
   in_beat_type                      req_beat;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [MODE_W*PACKED_DOORS-1:0]   rsp_door_modes;
   logic [LEVEL_W-1:0]               rsp_level_out;
   logic                             rsp_any_door_open;
   logic                             rsp_all_waiting;
   logic                             rsp_all_idle;
   logic                             rsp_changed;
   logic [TIME_W-1:0]                rsp_age_door0;
   logic [TIME_W-1:0]                rsp_age_door1;
   logic [TIME_W-1:0]                rsp_age_door2;
   logic [TIME_W-1:0]                rsp_age_door3;

   light_mode_scoreboard sb;
   int                   sender_idle_pct;
   int                   recv_stall_pct;
   int                   idle_cycles;
   logic [TIME_W-1:0]    clock_ms;
   logic [5:0]           side_bits;
   logic [LEVEL_W-1:0]   level_now;
   logic [SETTLE_W-1:0]  cur_settle;

   door_ambient_light_mode_fsm dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_now_ms           (req_beat.now_ms),
      .req_door_open        (req_beat.open_mask),
      .req_display_on       (req_beat.display_on),
      .req_blind_spot_right (req_beat.blind_spot_right),
      .req_blind_spot_left  (req_beat.blind_spot_left),
      .req_turn_right       (req_beat.turn_right),
      .req_turn_left        (req_beat.turn_left),
      .req_indicator_right  (req_beat.indicator_right),
      .req_indicator_left   (req_beat.indicator_left),
      .req_level_in         (req_beat.level_in),
      .req_clear_changed    (req_beat.clear_changed),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_door_modes       (rsp_door_modes),
      .rsp_level_out        (rsp_level_out),
      .rsp_any_door_open    (rsp_any_door_open),
      .rsp_all_waiting      (rsp_all_waiting),
      .rsp_all_idle         (rsp_all_idle),
      .rsp_changed          (rsp_changed),
      .rsp_age_door0        (rsp_age_door0),
      .rsp_age_door1        (rsp_age_door1),
      .rsp_age_door2        (rsp_age_door2),
      .rsp_age_door3        (rsp_age_door3)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // side: {blind right, blind left, turn right, turn left, indicator right, indicator left}
   function automatic in_beat_type snap(logic [TIME_W-1:0] now, logic [3:0] opens,
                                        logic disp, logic [5:0] side,
                                        logic [LEVEL_W-1:0] lvl, logic clr);
      in_beat_type b;
      b.now_ms           = now;
      b.open_mask        = opens;
      b.display_on       = disp;
      b.blind_spot_right = side[5];
      b.blind_spot_left  = side[4];
      b.turn_right       = side[3];
      b.turn_left        = side[2];
      b.indicator_right  = side[1];
      b.indicator_left   = side[0];
      b.level_in         = lvl;
      b.clear_changed    = clr;
      return b;
   endfunction

   function in_beat_type random_snapshot();
      logic [TIME_W-1:0] now;
      logic [3:0]        opens;
      int                i;
      case ($urandom_range(9))
         6, 7:    clock_ms = clock_ms + TIME_W'(cur_settle) + $urandom_range(0, 2);
         8:       clock_ms = clock_ms + $urandom;
         9:       clock_ms = $urandom;
         default: clock_ms = clock_ms + $urandom_range(0, 300);
      endcase
      now = clock_ms;
      for (i = 0; i < 6; i++)
         if ($urandom_range(99) < 25) side_bits[i] = ~side_bits[i];
      case ($urandom_range(4))
         0:       level_now = LEVEL_W'($urandom_range(0, 255));
         1:       level_now = LEVEL_W'($urandom_range(95, 105));
         default: ;
      endcase
      opens = ($urandom_range(99) < 75) ? 4'h0 : 4'($urandom_range(1, 15));
      return snap(now, opens, $urandom_range(99) < 88, side_bits, level_now,
                  $urandom_range(99) < 30);
   endfunction

   task automatic send_beat(in_beat_type b);
      logic taken;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_beat  = b;
      req_valid = 1'b1;
      taken     = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
         if (taken) sb.note_request(b);
         @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_settle(logic [SETTLE_W-1:0] value);
      csr_write_data   = value;
      csr_write_enable = 1'b1;
      @(posedge clock);
      sb.set_settle(value);
      cur_settle = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic run_directed();
      send_beat(snap(32'd0, 4'h0, 1'b0, 6'b000000, 8'd0, 1'b0));
      send_beat(snap(32'hFFFF_FFFF, 4'h0, 1'b1, 6'b000000, 8'hFF, 1'b1));
      send_beat(snap(32'd999, 4'h0, 1'b1, 6'b000000, 8'hFF, 1'b1));
      send_beat(snap(32'd1000, 4'h0, 1'b1, 6'b000000, 8'hFF, 1'b1));
      send_beat(snap(32'd1010, 4'h0, 1'b1, 6'b100000, 8'hFF, 1'b1));
      send_beat(snap(32'd1020, 4'h0, 1'b1, 6'b100011, 8'hFF, 1'b1));
      send_beat(snap(32'd1030, 4'h0, 1'b1, 6'b110011, 8'hFF, 1'b0));
      send_beat(snap(32'd1040, 4'h0, 1'b1, 6'b001100, 8'hFF, 1'b1));
      send_beat(snap(32'd1050, 4'h0, 1'b1, 6'b000000, 8'hFF, 1'b1));
      send_beat(snap(32'd1060, 4'h0, 1'b1, 6'b100010, 8'hFF, 1'b1));
      send_beat(snap(32'd1070, 4'h0, 1'b1, 6'b100000, 8'hFF, 1'b1));
      send_beat(snap(32'd1080, 4'hF, 1'b1, 6'b000000, 8'd50, 1'b1));
      send_beat(snap(32'd1090, 4'hF, 1'b1, 6'b000000, 8'd50, 1'b1));
      send_beat(snap(32'd1100, 4'h1, 1'b1, 6'b000000, 8'd99, 1'b1));
      send_beat(snap(32'd1110, 4'h8, 1'b1, 6'b000000, 8'd100, 1'b1));
      send_beat(snap(32'd1120, 4'h8, 1'b1, 6'b000000, 8'hFF, 1'b1));
      send_beat(snap(32'd1130, 4'h0, 1'b1, 6'b000000, 8'd0, 1'b1));
      send_beat(snap(32'd1140, 4'h0, 1'b0, 6'b000000, 8'd0, 1'b1));
      send_beat(snap(32'd1150, 4'h0, 1'b1, 6'b000000, 8'd0, 1'b1));
      send_beat(snap(32'd9000, 4'h0, 1'b1, 6'b111111, 8'd0, 1'b1));
      send_beat(snap(32'hFFFF_FF00, 4'h0, 1'b1, 6'b000000, 8'd0, 1'b1));
      clock_ms = 32'hFFFF_FF00;
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < recv_stall_pct);
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall)
            sb.check_result('{rsp_door_modes, rsp_level_out, rsp_any_door_open,
                              rsp_all_waiting, rsp_all_idle, rsp_changed,
                              {rsp_age_door3, rsp_age_door2, rsp_age_door1, rsp_age_door0}});
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic [SETTLE_W-1:0] plan [PHASES];
      int                  p;
      sb               = new();
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_beat         = '0;
      sender_idle_pct  = 0;
      recv_stall_pct   = 0;
      clock_ms         = '0;
      side_bits        = '0;
      level_now        = '0;
      cur_settle       = SETTLE_RESET;
      plan = '{SETTLE_RESET, 16'd0, 16'hFFFF, 16'($urandom_range(0, 65535)), 16'd1,
               16'($urandom_range(0, 2000))};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (p = 0; p < PHASES; p++) begin
         drain();
         write_settle(plan[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin sender_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         if (p == 0) run_directed();
         repeat (PHASE_BEATS) send_beat(random_snapshot());
      end
      drain();
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
